### rtl/rhc_pkg.sv
// Shared constants, types and tables of the RGB to HSV colour classifier.
package rhc_pkg;

    localparam int unsigned NUM_CHROMA = 8;

    localparam logic [12:0] Q_ONE  = 13'd4096;
    localparam logic [12:0] Q_0P20 = 13'd819;
    localparam logic [12:0] Q_0P25 = 13'd1024;
    localparam logic [12:0] Q_0P30 = 13'd1229;
    localparam logic [12:0] Q_0P70 = 13'd2867;

    localparam logic [15:0] RST_CHAN_MAX  = 16'd1000;
    localparam logic [12:0] RST_TOLERANCE = 13'd614;

    // configuration register indexes
    localparam logic [1:0] CFG_RED_MAX   = 2'd0;
    localparam logic [1:0] CFG_GREEN_MAX = 2'd1;
    localparam logic [1:0] CFG_BLUE_MAX  = 2'd2;
    localparam logic [1:0] CFG_TOLERANCE = 2'd3;

    typedef enum logic [3:0] {
        CLS_UNKNOWN = 4'd0,
        CLS_RED     = 4'd1,
        CLS_ORANGE  = 4'd2,
        CLS_YELLOW  = 4'd3,
        CLS_GREEN   = 4'd4,
        CLS_CYAN    = 4'd5,
        CLS_BLUE    = 4'd6,
        CLS_PURPLE  = 4'd7,
        CLS_MAGENTA = 4'd8,
        CLS_WHITE   = 4'd9,
        CLS_BLACK   = 4'd10
    } t_color_class;

    typedef struct packed {
        logic [11:0]  lo;
        logic [11:0]  hi;
        logic [12:0]  smin;
        logic [12:0]  vmin;
        t_color_class cls;
    } t_hue_bin;

    // hue bins in tenths of a degree, half open; the red bin wraps
    localparam t_hue_bin HUE_BINS [NUM_CHROMA] = '{
        '{12'd3400, 12'd200,  13'd2048, 13'd1229, CLS_RED},
        '{12'd200,  12'd500,  13'd2048, 13'd1638, CLS_ORANGE},
        '{12'd500,  12'd800,  13'd2048, 13'd2048, CLS_YELLOW},
        '{12'd800,  12'd1650, 13'd1638, 13'd1229, CLS_GREEN},
        '{12'd1650, 12'd2100, 13'd1638, 13'd1638, CLS_CYAN},
        '{12'd2100, 12'd2650, 13'd1638, 13'd1229, CLS_BLUE},
        '{12'd2650, 12'd2950, 13'd1638, 13'd1229, CLS_PURPLE},
        '{12'd2950, 12'd3400, 13'd2048, 13'd1638, CLS_MAGENTA}
    };

    // value in Q0.12 from the largest level, floor(mx*4096/255):
    // 4096/255 = 16 + 16/255, and floor(y/255) = (y + 1 + (y >> 8)) >> 8 for small y
    function automatic logic [12:0] value_q12(input logic [7:0] mx);
        logic [12:0] y;
        logic [12:0] t;
        y = {1'b0, mx, 4'd0};
        t = y + 13'd1 + {9'd0, mx[7:4]};
        return y + {8'd0, t[12:8]};
    endfunction

endpackage

### rtl/rgb_hsv_color_classifier.sv
// Top level: normalise raw RGB, convert to HSV and classify the colour.
//
// Input channel: i_in_valid with the three raw 16-bit counts; a transaction
// is taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid with levels, hue, saturation, value, class and
// match mask; a transaction completes when o_out_valid is high and
// i_out_stall is low. Every input transaction gives exactly one result.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 red max, 1 green max, 2 blue max, 3 tolerance); the user must write only
// while the block is idle, which the block does not enforce. The input stage
// loads at the accepting edge, then come eight stages of the channel scaling
// divider, two stages of HSV setup, thirteen stages of the hue and saturation
// dividers and the output stage. Throughput is one transaction per cycle
// while the receiver does not stall. When the receiver stalls with a result
// waiting, the whole pipeline holds and o_in_stall rises in the same cycle;
// nothing is lost or repeated. Synchronous reset clears all valid bits and
// loads the default calibration (maxima 1000, tolerance 614).
module rgb_hsv_color_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_raw_red,
    input  logic [15:0] i_raw_green,
    input  logic [15:0] i_raw_blue,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_green_level,
    output logic [7:0]  o_blue_level,
    output logic [11:0] o_hue_tenths,
    output logic [12:0] o_saturation_q12,
    output logic [12:0] o_value_q12,
    output logic [3:0]  o_color_class,
    output logic [9:0]  o_match_mask,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int LDIV_N = 8;
    localparam int HDIV_N = 13;

    // configuration
    logic [15:0] r_max [3];
    logic [12:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max[0] <= rhc_pkg::RST_CHAN_MAX;
            r_max[1] <= rhc_pkg::RST_CHAN_MAX;
            r_max[2] <= rhc_pkg::RST_CHAN_MAX;
            r_tol    <= rhc_pkg::RST_TOLERANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rhc_pkg::CFG_RED_MAX:   r_max[0] <= i_cfg_data;
                rhc_pkg::CFG_GREEN_MAX: r_max[1] <= i_cfg_data;
                rhc_pkg::CFG_BLUE_MAX:  r_max[2] <= i_cfg_data;
                rhc_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished result is held by the receiver
    logic w_en;
    logic r_vld_o;
    assign w_en       = !r_vld_o || !i_out_stall;
    assign o_in_stall = !w_en;

    // input stage: raw*255 and divisor capture
    logic        r_vld_in;
    logic [23:0] r_num [3];
    logic [15:0] r_den [3];
    logic [15:0] w_raw [3];
    assign w_raw[0] = i_raw_red;
    assign w_raw[1] = i_raw_green;
    assign w_raw[2] = i_raw_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
        end else if (w_en) begin
            r_vld_in <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= {w_raw[c], 8'd0} - 24'(w_raw[c]);
                r_den[c] <= r_max[c];
            end
        end
    end

    // channel scaling dividers with zero and overflow flags alongside
    logic [7:0] w_lq [3];
    logic       r_vld_l [LDIV_N];
    logic [2:0] r_zf_l  [LDIV_N];
    logic [2:0] r_ov_l  [LDIV_N];

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_ldiv
            rhc_div #(.NUM_W(24), .DEN_W(16), .Q_W(LDIV_N)) u_ldiv (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (r_num[c]),
                .i_den (r_den[c]),
                .o_quo (w_lq[c])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LDIV_N; i++) r_vld_l[i] <= 1'b0;
        end else if (w_en) begin
            r_vld_l[0] <= r_vld_in;
            for (int i = 1; i < LDIV_N; i++) r_vld_l[i] <= r_vld_l[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_zf_l[0][k] <= (r_den[k] == 16'd0);
                r_ov_l[0][k] <= ({1'b0, r_num[k]} >= {1'b0, r_den[k], 8'd0});
            end
            for (int i = 1; i < LDIV_N; i++) begin
                r_zf_l[i] <= r_zf_l[i-1];
                r_ov_l[i] <= r_ov_l[i-1];
            end
        end
    end

    // stage A: levels, extremes and hue numerator before scaling
    logic [7:0]  w_lv [3];
    logic [7:0]  w_mx, w_mn, w_d;
    logic [10:0] w_x;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_zf_l[LDIV_N-1][k]) w_lv[k] = 8'd0;
            else if (r_ov_l[LDIV_N-1][k]) w_lv[k] = 8'd255;
            else w_lv[k] = w_lq[k];
        end
        w_mx = w_lv[0];
        w_mn = w_lv[0];
        if (w_lv[1] > w_mx) w_mx = w_lv[1];
        if (w_lv[2] > w_mx) w_mx = w_lv[2];
        if (w_lv[1] < w_mn) w_mn = w_lv[1];
        if (w_lv[2] < w_mn) w_mn = w_lv[2];
        w_d = w_mx - w_mn;
        if (w_mx == w_lv[0]) begin
            if (w_lv[1] >= w_lv[2]) w_x = 11'(w_lv[1] - w_lv[2]);
            else w_x = 11'(w_d) * 11'd6 - 11'(w_lv[2]) + 11'(w_lv[1]);
        end else if (w_mx == w_lv[1]) begin
            w_x = {2'd0, w_d, 1'b0} + 11'(w_lv[2]) - 11'(w_lv[0]);
        end else begin
            w_x = {1'b0, w_d, 2'd0} + 11'(w_lv[0]) - 11'(w_lv[1]);
        end
    end

    logic        r_vld_a;
    logic [23:0] r_lv_a;
    logic [7:0]  r_mx_a, r_d_a;
    logic [10:0] r_x_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (w_en) begin
            r_vld_a <= r_vld_l[LDIV_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lv_a <= {w_lv[0], w_lv[1], w_lv[2]};
            r_mx_a <= w_mx;
            r_d_a  <= w_d;
            r_x_a  <= w_x;
        end
    end

    // stage B: dividends, divisors and value
    logic        r_vld_b;
    logic [23:0] r_lv_b;
    logic [19:0] r_hnum_b, r_snum_b;
    logic [7:0]  r_hden_b, r_sden_b;
    logic [12:0] r_val_b;
    logic        r_gray_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (w_en) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lv_b   <= r_lv_a;
            r_hnum_b <= 20'(21'(r_x_a) * 21'd600);
            r_snum_b <= {r_d_a, 12'd0};
            r_hden_b <= r_d_a;
            r_sden_b <= r_mx_a;
            r_val_b  <= rhc_pkg::value_q12(r_mx_a);
            r_gray_b <= (r_d_a == 8'd0);
        end
    end

    // hue and saturation dividers with the rest of the item alongside
    logic [12:0] w_hq, w_sq;
    logic        r_vld_h  [HDIV_N];
    logic [23:0] r_lv_h   [HDIV_N];
    logic [12:0] r_val_h  [HDIV_N];
    logic        r_gray_h [HDIV_N];

    rhc_div #(.NUM_W(20), .DEN_W(8), .Q_W(HDIV_N)) u_hdiv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_hnum_b),
        .i_den (r_hden_b),
        .o_quo (w_hq)
    );

    rhc_div #(.NUM_W(20), .DEN_W(8), .Q_W(HDIV_N)) u_sdiv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_snum_b),
        .i_den (r_sden_b),
        .o_quo (w_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HDIV_N; i++) r_vld_h[i] <= 1'b0;
        end else if (w_en) begin
            r_vld_h[0] <= r_vld_b;
            for (int i = 1; i < HDIV_N; i++) r_vld_h[i] <= r_vld_h[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lv_h[0]   <= r_lv_b;
            r_val_h[0]  <= r_val_b;
            r_gray_h[0] <= r_gray_b;
            for (int i = 1; i < HDIV_N; i++) begin
                r_lv_h[i]   <= r_lv_h[i-1];
                r_val_h[i]  <= r_val_h[i-1];
                r_gray_h[i] <= r_gray_h[i-1];
            end
        end
    end

    // stage C: class tests and priority
    logic [11:0]          w_hue;
    logic [12:0]          w_sat, w_val, w_tolc;
    logic signed [14:0]   w_s, w_v, w_t;
    logic [9:0]           w_mask;
    rhc_pkg::t_color_class w_cls;
    rhc_pkg::t_hue_bin     w_bin;
    logic                  w_inbin;

    always_comb begin
        w_hue  = r_gray_h[HDIV_N-1] ? 12'd0 : w_hq[11:0];
        w_sat  = r_gray_h[HDIV_N-1] ? 13'd0 : w_sq;
        w_val  = r_val_h[HDIV_N-1];
        w_tolc = (r_tol > rhc_pkg::Q_ONE) ? rhc_pkg::Q_ONE : r_tol;
        w_s    = $signed({2'b00, w_sat});
        w_v    = $signed({2'b00, w_val});
        w_t    = $signed({2'b00, w_tolc});
        w_mask = '0;
        w_bin  = rhc_pkg::HUE_BINS[0];
        w_inbin = 1'b0;
        for (int k = 0; k < rhc_pkg::NUM_CHROMA; k++) begin
            w_bin = rhc_pkg::HUE_BINS[k];
            if (w_bin.lo < w_bin.hi) w_inbin = (w_hue >= w_bin.lo) && (w_hue < w_bin.hi);
            else w_inbin = (w_hue >= w_bin.lo) || (w_hue < w_bin.hi);
            w_mask[k] = w_inbin
                && (w_s >= $signed({2'b00, w_bin.smin}) - w_t)
                && (w_v >= $signed({2'b00, w_bin.vmin}) - w_t);
        end
        w_mask[8] = (w_s <= $signed({2'b00, rhc_pkg::Q_0P20}) + w_t)
                 && (w_v >= $signed({2'b00, rhc_pkg::Q_0P70}) - w_t);
        w_mask[9] = (w_v <= $signed({2'b00, rhc_pkg::Q_0P20}) + w_t);

        w_cls = rhc_pkg::CLS_UNKNOWN;
        if (w_mask[9]) begin
            w_cls = rhc_pkg::CLS_BLACK;
        end else if (w_mask[8]) begin
            w_cls = rhc_pkg::CLS_WHITE;
        end else if ((w_s < $signed({2'b00, rhc_pkg::Q_0P30}) - w_t)
                  || (w_v < $signed({2'b00, rhc_pkg::Q_0P25}) - w_t)) begin
            w_cls = rhc_pkg::CLS_UNKNOWN;
        end else begin
            for (int k = rhc_pkg::NUM_CHROMA - 1; k >= 0; k--) begin
                if (w_mask[k]) w_cls = rhc_pkg::HUE_BINS[k].cls;
            end
        end
    end

    // output register
    logic [23:0] r_lv_o;
    logic [11:0] r_hue_o;
    logic [12:0] r_sat_o, r_val_o;
    logic [3:0]  r_cls_o;
    logic [9:0]  r_mask_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (w_en) begin
            r_vld_o <= r_vld_h[HDIV_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lv_o   <= r_lv_h[HDIV_N-1];
            r_hue_o  <= w_hue;
            r_sat_o  <= w_sat;
            r_val_o  <= w_val;
            r_cls_o  <= w_cls;
            r_mask_o <= w_mask;
        end
    end

    assign o_out_valid      = r_vld_o;
    assign o_red_level      = r_lv_o[23:16];
    assign o_green_level    = r_lv_o[15:8];
    assign o_blue_level     = r_lv_o[7:0];
    assign o_hue_tenths     = r_hue_o;
    assign o_saturation_q12 = r_sat_o;
    assign o_value_q12      = r_val_o;
    assign o_color_class    = r_cls_o;
    assign o_match_mask     = r_mask_o;

    // black wins over every other class
    a_black_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match_mask[9] |-> o_color_class == rhc_pkg::CLS_BLACK)
        else $error("black match not reported as black");

    // hue stays inside one turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hue_tenths < 12'd3600)
        else $error("hue out of range");

    // grey input has no hue
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturation_q12 == 13'd0 |-> o_hue_tenths == 12'd0)
        else $error("grey item with non-zero hue");

endmodule

### rtl/rhc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module rhc_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16,
    parameter int Q_W   = 8
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    localparam int RW = NUM_W + DEN_W;

    logic [RW-1:0]    r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    genvar s;
    generate
        for (s = 0; s < Q_W; s++) begin : g_stage
            logic [RW-1:0]    w_rem;
            logic [DEN_W-1:0] w_den;
            logic [Q_W-1:0]   w_quo;
            logic [RW-1:0]    w_sub;

            if (s == 0) begin : g_first
                assign w_rem = RW'(i_num);
                assign w_den = i_den;
                assign w_quo = '0;
            end else begin : g_next
                assign w_rem = r_rem[s-1];
                assign w_den = r_den[s-1];
                assign w_quo = r_quo[s-1];
            end

            assign w_sub = RW'(w_den) << (Q_W - 1 - s);

            // try the shifted divisor, keep the difference when it fits
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= w_den;
                    if (w_rem >= w_sub) begin
                        r_rem[s] <= w_rem - w_sub;
                        r_quo[s] <= w_quo | (Q_W'(1) << (Q_W - 1 - s));
                    end else begin
                        r_rem[s] <= w_rem;
                        r_quo[s] <= w_quo;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[Q_W-1];

endmodule
